### src/mrupr_pkg.sv
// Shared constants and types for the MRU page replacement unit.
package mrupr_pkg;

	// Default sizes of the frame table
	localparam int FRAMES_DEF    = 16;
	localparam int PAGE_BITS_DEF = 16;

	// Fixed widths of the port fields
	localparam int PAGE_W  = 16;
	localparam int SLOT_W  = 4;
	localparam int COUNT_W = 32;
	localparam int FIU_W   = 5;

	// Configuration port
	localparam int             CFG_ADDR_W        = 3;
	localparam int             CFG_DATA_W        = 32;
	localparam logic           REG_FRAMES_IN_USE = 1'b0;
	localparam logic [FIU_W-1:0] FIU_RESET       = 5'd16;

	localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

	// Sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_EV_RD,
		ST_EV_CAP,
		ST_UPDATE
	} state_t;

endpackage

### src/mrupr_ram.sv
// Generic single-write, single-read RAM with registered read data.
module mrupr_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 16,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

### src/mru_page_replacement_unit.sv
// Top level of the MRU page replacement unit: sequencer, frame scan and result register.
//
// Fully associative page-frame table with most-recently-used replacement.
// Input channel (in_valid/in_ready, page_number): one page reference per
// transaction. Output channel (out_valid/out_ready): one result per reference
// with hit flag, frame slot, eviction flag and evicted page, and saturating
// hit and fault totals.
// Configuration: APB-style write of frames_in_use at byte address 0; clamped
// to 1..FRAMES when a reference starts. Write it only while the unit is idle.
// Scan: the page store is scanned through one RAM read port and one
// comparator, one frame per cycle, in ascending order, stopping at the first
// hit. A hit goes straight to the update step; a miss scans every frame in
// use, then goes to the update step if a free frame was found, else reads the
// evicted page in the read and capture steps first; then the unit idles again.
// in_ready is high only while the sequencer is idle; a finished result sits in
// the output register, so the next reference is accepted while it waits.
// When the receiver stalls, the next result holds in the update step until
// the output register frees up.
// Reset: all frames invalid, last-touched frame 0, totals 0, frames_in_use 16.
module mru_page_replacement_unit #(
	parameter int FRAMES    = mrupr_pkg::FRAMES_DEF,
	parameter int PAGE_BITS = mrupr_pkg::PAGE_BITS_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	// Configuration port
	input  logic                                 psel,
	input  logic                                 penable,
	input  logic                                 pwrite,
	input  logic [mrupr_pkg::CFG_ADDR_W-1:0]     paddr,
	input  logic [mrupr_pkg::CFG_DATA_W-1:0]     pwdata,
	output logic [mrupr_pkg::CFG_DATA_W-1:0]     prdata,
	output logic                                 pready,
	// Reference channel
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic [mrupr_pkg::PAGE_W-1:0]         page_number,
	// Result channel
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic                                 was_hit,
	output logic [mrupr_pkg::SLOT_W-1:0]         frame_slot,
	output logic                                 did_evict,
	output logic [mrupr_pkg::PAGE_W-1:0]         evicted_page,
	output logic [mrupr_pkg::COUNT_W-1:0]        hit_total,
	output logic [mrupr_pkg::COUNT_W-1:0]        fault_total
);

	import mrupr_pkg::*;

	localparam int SW = (FRAMES > 1) ? $clog2(FRAMES) : 1;
	localparam int CW = $clog2(FRAMES + 1);

	// Configuration register
	logic [FIU_W-1:0] fiu_q;
	logic             cfg_wr;

	// Sequencer
	state_t state_q, state_d;

	// Reference context
	logic [PAGE_BITS-1:0] page_q;
	logic [CW-1:0]        n_q;
	logic [31:0]          n_clamp;

	// Scan
	logic [CW-1:0] rd_cnt_q;
	logic          cmp_vld_s1;
	logic [SW-1:0] cmp_idx_s1;
	logic          free_found_q;
	logic [SW-1:0] free_slot_q;
	logic          cur_valid;
	logic          scan_hit;
	logic          scan_last;
	logic          scan_free;
	logic [SW-1:0] scan_free_slot;
	logic          issue_rd;
	logic [SW-1:0] stale_slot;

	// Outcome of the current reference
	logic                 hit_q;
	logic                 evict_q;
	logic [SW-1:0]        slot_q;
	logic [PAGE_BITS-1:0] old_q;

	// Table state
	logic [FRAMES-1:0] valid_q;
	logic [SW-1:0]     last_q;
	logic [COUNT_W-1:0] hit_cnt_q, fault_cnt_q;
	logic [COUNT_W-1:0] hit_cnt_d, fault_cnt_d;

	// Page store
	logic                 ram_we, ram_re;
	logic [SW-1:0]        ram_raddr;
	logic [PAGE_BITS-1:0] ram_rdata;

	// Result register
	logic                 out_valid_q;
	logic                 res_hit_q, res_evict_q;
	logic [SW-1:0]        res_slot_q;
	logic [PAGE_BITS-1:0] res_old_q;
	logic [COUNT_W-1:0]   res_hit_tot_q, res_fault_tot_q;

	logic accept;
	logic update_fire;

	// Configuration port: always ready, one register
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite
		&& (paddr[CFG_ADDR_W-1] == REG_FRAMES_IN_USE);
	assign prdata = (paddr[CFG_ADDR_W-1] == REG_FRAMES_IN_USE)
		? CFG_DATA_W'(fiu_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fiu_q <= FIU_RESET;
		end else if (cfg_wr) begin
			fiu_q <= pwdata[FIU_W-1:0];
		end
	end

	// Clamp the frame count to 1..FRAMES
	always_comb begin
		n_clamp = 32'(fiu_q);
		if (n_clamp == 32'd0) begin
			n_clamp = 32'd1;
		end else if (n_clamp > 32'(FRAMES)) begin
			n_clamp = 32'(FRAMES);
		end
	end

	// Compare stage: one frame per cycle through the shared comparator
	assign cur_valid = valid_q[cmp_idx_s1];
	assign scan_hit  = cmp_vld_s1 && cur_valid && (ram_rdata == page_q);
	assign scan_last = cmp_vld_s1 && ((CW'(cmp_idx_s1) + CW'(1)) == n_q);
	assign scan_free = free_found_q || (cmp_vld_s1 && !cur_valid);
	assign scan_free_slot = free_found_q ? free_slot_q : cmp_idx_s1;
	assign stale_slot = (32'(last_q) < 32'(n_q)) ? last_q : SW'(n_q - CW'(1));

	assign accept      = in_valid && in_ready;
	assign update_fire = (state_q == ST_UPDATE) && (!out_valid_q || out_ready);

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (scan_hit) begin
					state_d = ST_UPDATE;
				end else if (scan_last) begin
					state_d = scan_free ? ST_UPDATE : ST_EV_RD;
				end
			end
			ST_EV_RD:  state_d = ST_EV_CAP;
			ST_EV_CAP: state_d = ST_UPDATE;
			ST_UPDATE: begin
				if (!out_valid_q || out_ready) begin
					state_d = ST_IDLE;
				end
			end
			default:   state_d = ST_IDLE;
		endcase
	end

	// Sequencer outputs
	always_comb begin
		in_ready  = 1'b0;
		issue_rd  = 1'b0;
		ram_re    = 1'b0;
		ram_raddr = rd_cnt_q[SW-1:0];
		ram_we    = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
			end
			ST_SCAN: begin
				issue_rd = (rd_cnt_q < n_q) && !scan_hit;
				ram_re   = issue_rd;
			end
			ST_EV_RD: begin
				ram_re    = 1'b1;
				ram_raddr = slot_q;
			end
			ST_UPDATE: begin
				ram_we = update_fire && !hit_q;
			end
			default: begin
				in_ready = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Scan control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_cnt_q     <= '0;
			cmp_vld_s1   <= 1'b0;
			free_found_q <= 1'b0;
		end else if (accept) begin
			rd_cnt_q     <= '0;
			cmp_vld_s1   <= 1'b0;
			free_found_q <= 1'b0;
		end else if (state_q == ST_SCAN) begin
			cmp_vld_s1 <= issue_rd;
			if (issue_rd) begin
				rd_cnt_q <= rd_cnt_q + CW'(1);
			end
			if (cmp_vld_s1 && !cur_valid && !free_found_q) begin
				free_found_q <= 1'b1;
			end
		end
	end

	// Scan datapath and reference outcome
	always_ff @(posedge clk) begin
		if (accept) begin
			page_q  <= PAGE_BITS'(page_number);
			n_q     <= CW'(n_clamp);
			hit_q   <= 1'b0;
			evict_q <= 1'b0;
			old_q   <= '0;
		end else begin
			case (state_q)
				ST_SCAN: begin
					cmp_idx_s1 <= rd_cnt_q[SW-1:0];
					if (cmp_vld_s1 && !cur_valid && !free_found_q) begin
						free_slot_q <= cmp_idx_s1;
					end
					if (scan_hit) begin
						hit_q  <= 1'b1;
						slot_q <= cmp_idx_s1;
					end else if (scan_last) begin
						if (scan_free) begin
							slot_q <= scan_free_slot;
						end else begin
							slot_q  <= stale_slot;
							evict_q <= 1'b1;
						end
					end
				end
				ST_EV_CAP: begin
					old_q <= ram_rdata;
				end
				default: begin
					old_q <= old_q;
				end
			endcase
		end
	end

	// Saturating totals after this reference
	always_comb begin
		hit_cnt_d   = hit_cnt_q;
		fault_cnt_d = fault_cnt_q;
		if (hit_q) begin
			if (hit_cnt_q != COUNT_MAX) begin
				hit_cnt_d = hit_cnt_q + COUNT_W'(1);
			end
		end else if (fault_cnt_q != COUNT_MAX) begin
			fault_cnt_d = fault_cnt_q + COUNT_W'(1);
		end
	end

	// Commit the reference to the table state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q     <= '0;
			last_q      <= '0;
			hit_cnt_q   <= '0;
			fault_cnt_q <= '0;
		end else if (update_fire) begin
			if (!hit_q) begin
				valid_q[slot_q] <= 1'b1;
			end
			last_q      <= slot_q;
			hit_cnt_q   <= hit_cnt_d;
			fault_cnt_q <= fault_cnt_d;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (update_fire) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (update_fire) begin
			res_hit_q       <= hit_q;
			res_evict_q     <= evict_q;
			res_slot_q      <= slot_q;
			res_old_q       <= old_q;
			res_hit_tot_q   <= hit_cnt_d;
			res_fault_tot_q <= fault_cnt_d;
		end
	end

	assign out_valid    = out_valid_q;
	assign was_hit      = res_hit_q;
	assign frame_slot   = SLOT_W'(res_slot_q);
	assign did_evict    = res_evict_q;
	assign evicted_page = PAGE_W'(res_old_q);
	assign hit_total    = res_hit_tot_q;
	assign fault_total  = res_fault_tot_q;

	// Page store
	mrupr_ram #(
		.WIDTH (PAGE_BITS),
		.DEPTH (FRAMES),
		.AW    (SW)
	) u_pages (
		.clk   (clk),
		.we    (ram_we),
		.waddr (slot_q),
		.wdata (page_q),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// The store is written only when a miss is committed
	a_write_on_miss: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> (state_q == ST_UPDATE) && !hit_q)
		else $error("page store written outside a committed miss");

	// Scan reads stay within the frames in use
	a_scan_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(ram_re && (state_q == ST_SCAN)) |-> (CW'(ram_raddr) < n_q))
		else $error("scan read beyond frames in use");

	// Valid bits are only ever set
	a_valid_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		1'b1 |=> ((valid_q & $past(valid_q)) == $past(valid_q)))
		else $error("frame valid bit cleared");

	// An accepted reference starts a scan
	a_accept_scan: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q == ST_SCAN))
		else $error("accepted reference did not start a scan");

	// Totals never decrease
	a_totals_mono: assert property (@(posedge clk) disable iff (!arst_n)
		1'b1 |=> (hit_cnt_q >= $past(hit_cnt_q)) && (fault_cnt_q >= $past(fault_cnt_q)))
		else $error("running total decreased");

endmodule

### tb/tb_top.sv
// Self-checking testbench for the MRU page replacement unit: reference driver, result monitor.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import mrupr_pkg::*;

	localparam int unsigned CYCLE_LIMIT = 1_000_000;
	localparam int unsigned END_DRAIN   = 30;
	localparam logic [CFG_ADDR_W-1:0] FIU_ADDR = CFG_ADDR_W'(4 * int'(REG_FRAMES_IN_USE));

	typedef struct packed {
		logic               hit;
		logic [SLOT_W-1:0]  slot;
		logic               evict;
		logic [PAGE_W-1:0]  old_page;
		logic [COUNT_W-1:0] hits;
		logic [COUNT_W-1:0] faults;
	} page_result_t;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	logic                  psel    = 1'b0;
	logic                  penable = 1'b0;
	logic                  pwrite  = 1'b0;
	logic [CFG_ADDR_W-1:0] paddr   = '0;
	logic [CFG_DATA_W-1:0] pwdata  = '0;
	logic [CFG_DATA_W-1:0] prdata;
	logic                  pready;

	logic              in_valid    = 1'b0;
	logic              in_ready;
	logic [PAGE_W-1:0] page_number = '0;

	logic               out_valid;
	logic               out_ready = 1'b0;
	logic               was_hit;
	logic [SLOT_W-1:0]  frame_slot;
	logic               did_evict;
	logic [PAGE_W-1:0]  evicted_page;
	logic [COUNT_W-1:0] hit_total;
	logic [COUNT_W-1:0] fault_total;

	// Mirror of the frame table and the configured frame count
	logic [PAGE_W-1:0]  mirror_page [FRAMES_DEF];
	bit                 mirror_valid[FRAMES_DEF];
	int unsigned        mirror_mru;
	logic [COUNT_W-1:0] mirror_hits;
	logic [COUNT_W-1:0] mirror_faults;
	logic [FIU_W-1:0]   frames_cfg = FIU_RESET;

	logic [PAGE_W-1:0] page_queue[$];
	page_result_t      pending_results[$];

	int unsigned in_gap     = 0;
	int unsigned out_stall  = 0;
	bit          in_idle_on  = 1'b1;
	bit          out_idle_on = 1'b1;
	int unsigned cycle_count = 0;
	int unsigned err_count   = 0;
	int unsigned refs_sent   = 0;
	int unsigned results_seen = 0;
	int unsigned hits_seen   = 0;
	int unsigned evicts_seen = 0;
	int unsigned settings_used = 0;

	mru_page_replacement_unit u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.page_number  (page_number),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.was_hit      (was_hit),
		.frame_slot   (frame_slot),
		.did_evict    (did_evict),
		.evicted_page (evicted_page),
		.hit_total    (hit_total),
		.fault_total  (fault_total)
	);

	always #10 clk = ~clk;

	// Clamp the programmed frame count to the usable range
	function automatic int unsigned frames_active(input logic [FIU_W-1:0] cfg);
		if (cfg == 0)
			return 1;
		if (cfg > FRAMES_DEF)
			return FRAMES_DEF;
		return int'(cfg);
	endfunction

	// Apply one page reference to the mirror table and return the result it produces
	function automatic page_result_t predict_reference(input logic [PAGE_W-1:0] page);
		page_result_t r;
		int unsigned  n;
		int unsigned  slot;
		bit           found;
		r     = '0;
		n     = frames_active(frames_cfg);
		slot  = 0;
		found = 1'b0;
		// hit: lowest valid frame in use holding the page
		for (int i = 0; i < n; i++) begin
			if (!found && mirror_valid[i] && mirror_page[i] == page) begin
				slot  = i;
				found = 1'b1;
				r.hit = 1'b1;
			end
		end
		// free frame: lowest empty frame in use
		for (int i = 0; i < n; i++) begin
			if (!found && !mirror_valid[i]) begin
				slot  = i;
				found = 1'b1;
			end
		end
		// full table: overwrite the most recent frame, or the top frame if it fell out of use
		if (!found) begin
			slot       = (mirror_mru < n) ? mirror_mru : n - 1;
			r.evict    = 1'b1;
			r.old_page = mirror_page[slot];
		end
		if (r.hit) begin
			if (mirror_hits != COUNT_MAX)
				mirror_hits = mirror_hits + 1;
		end else begin
			mirror_page[slot]  = page;
			mirror_valid[slot] = 1'b1;
			if (mirror_faults != COUNT_MAX)
				mirror_faults = mirror_faults + 1;
		end
		mirror_mru = slot;
		r.slot     = SLOT_W'(slot);
		r.hits     = mirror_hits;
		r.faults   = mirror_faults;
		return r;
	endfunction

	// Pick an idle length: mostly none or short, now and then long
	function automatic int unsigned idle_len();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 15);
		return $urandom_range(20, 80);
	endfunction

	function automatic void check_field(input string name, input logic [COUNT_W-1:0] exp_v,
			input logic [COUNT_W-1:0] act_v);
		if (exp_v !== act_v) begin
			$display("%0t: %s mismatch: expected 0x%0h, got 0x%0h", $time, name, exp_v, act_v);
			err_count++;
		end
	endfunction

	// Reference driver: predict on each accepted transaction, then present the next page
	always @(posedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			in_gap   <= 0;
		end else if (!in_valid || in_ready) begin
			if (in_valid) begin
				pending_results.push_back(predict_reference(page_number));
				refs_sent++;
			end
			if (in_gap != 0) begin
				in_valid <= 1'b0;
				in_gap   <= in_gap - 1;
			end else if (page_queue.size() != 0) begin
				in_valid    <= 1'b1;
				page_number <= page_queue.pop_front();
				in_gap      <= in_idle_on ? idle_len() : 0;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Result monitor: compare each transaction with the oldest prediction, stall at random
	always @(posedge clk) begin
		page_result_t exp_r;
		if (!arst_n) begin
			out_ready <= 1'b0;
			out_stall <= 0;
		end else begin
			if (out_valid && out_ready) begin
				results_seen++;
				if (pending_results.size() == 0) begin
					$display("%0t: result with no reference pending: hit=%0b slot=%0d",
						$time, was_hit, frame_slot);
					err_count++;
				end else begin
					exp_r = pending_results.pop_front();
					check_field("was_hit", exp_r.hit, was_hit);
					check_field("frame_slot", exp_r.slot, frame_slot);
					check_field("did_evict", exp_r.evict, did_evict);
					check_field("evicted_page", exp_r.old_page, evicted_page);
					check_field("hit_total", exp_r.hits, hit_total);
					check_field("fault_total", exp_r.faults, fault_total);
					if (exp_r.hit)
						hits_seen++;
					if (exp_r.evict)
						evicts_seen++;
				end
			end
			if (out_stall != 0) begin
				out_ready <= 1'b0;
				out_stall <= out_stall - 1;
			end else begin
				out_ready <= 1'b1;
				if (out_idle_on && ((out_valid && out_ready) || $urandom_range(0, 19) == 0))
					out_stall <= idle_len();
			end
		end
	end

	// Watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("%0t: timeout after %0d cycles, %0d results outstanding",
				$time, cycle_count, pending_results.size());
			$display("mru_page_replacement_unit verification failed");
			$finish;
		end
	end

	// Write the frame count over the config port and read it back
	task automatic set_frames(input logic [FIU_W-1:0] val);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= FIU_ADDR;
		pwdata  <= {27'($urandom_range(0, 32'h07FF_FFFF)), val};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		frames_cfg = val;
		pwrite  <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		if (prdata[FIU_W-1:0] !== val) begin
			$display("%0t: frames_in_use readback: expected 0x%0h, got 0x%0h",
				$time, val, prdata[FIU_W-1:0]);
			err_count++;
		end
		psel    <= 1'b0;
		penable <= 1'b0;
		settings_used++;
	endtask

	// Hold until every queued reference is accepted and answered
	task automatic drain();
		while (page_queue.size() != 0 || in_valid || pending_results.size() != 0)
			@(posedge clk);
	endtask

	initial begin
		int unsigned      n_eff;
		int unsigned      n_items;
		logic [FIU_W-1:0] cfg_val;
		logic [PAGE_W-1:0] pool[$];

		for (int i = 0; i < FRAMES_DEF; i++) begin
			mirror_page[i]  = '0;
			mirror_valid[i] = 1'b0;
		end
		mirror_mru    = 0;
		mirror_hits   = '0;
		mirror_faults = '0;

		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Reset setting: extreme pages fill free frames, then hits, ending on frame 3
		page_queue.push_back(16'h0000);
		page_queue.push_back(16'hFFFF);
		page_queue.push_back(16'hAAAA);
		page_queue.push_back(16'h5555);
		page_queue.push_back(16'hFFFF);
		page_queue.push_back(16'h0000);
		page_queue.push_back(16'h5555);
		drain();

		// Two frames: most recent frame is out of use, so frame 1 is evicted; then hits and an MRU eviction
		set_frames(5'd2);
		page_queue.push_back(16'h1234);
		page_queue.push_back(16'h0000);
		page_queue.push_back(16'h7777);
		page_queue.push_back(16'h1234);
		drain();

		// Zero frames acts as one
		set_frames(5'd0);
		page_queue.push_back(16'h5555);
		page_queue.push_back(16'h5555);
		drain();

		// Count above the table size: page resident twice hits the lower frame
		set_frames(5'd31);
		page_queue.push_back(16'h5555);
		page_queue.push_back(16'hAAAA);
		page_queue.push_back(16'h1234);
		page_queue.push_back(16'h0F0F);
		drain();

		set_frames(5'd17);
		page_queue.push_back(16'h5555);
		page_queue.push_back(16'hF0F0);
		drain();

		// Random phases: working sets sized around the frame count, with some noise pages
		for (int ph = 0; ph < 13; ph++) begin
			case (ph)
				0: cfg_val = 5'd1;
				1: cfg_val = 5'd16;
				2: cfg_val = 5'd0;
				3: cfg_val = 5'd31;
				4: cfg_val = 5'd4;
				default: begin
					if ($urandom_range(0, 9) < 6)
						cfg_val = FIU_W'($urandom_range(1, 6));
					else
						cfg_val = FIU_W'($urandom_range(0, 31));
				end
			endcase
			in_idle_on  = (ph != 1) && ($urandom_range(0, 3) != 0);
			out_idle_on = (ph != 1) && ($urandom_range(0, 3) != 0);
			set_frames(cfg_val);
			n_eff   = frames_active(cfg_val);
			n_items = $urandom_range(80, 110);
			pool.delete();
			repeat ($urandom_range(1, 2 * n_eff + 3))
				pool.push_back(PAGE_W'($urandom_range(0, 65535)));
			repeat (n_items) begin
				if ($urandom_range(0, 99) < 85)
					page_queue.push_back(pool[$urandom_range(0, pool.size() - 1)]);
				else
					page_queue.push_back(PAGE_W'($urandom_range(0, 65535)));
			end
			drain();
		end

		repeat (END_DRAIN) @(posedge clk);
		if (pending_results.size() != 0) begin
			$display("%0t: %0d predicted results never arrived", $time, pending_results.size());
			err_count++;
		end
		$display("Checked %0d page references over %0d frame-count settings.",
			results_seen, settings_used);
		$display("Of these %0d hit and %0d evicted a resident page; %0d errors.",
			hits_seen, evicts_seen, err_count);
		if (err_count == 0)
			$display("mru_page_replacement_unit verification clean");
		else
			$display("mru_page_replacement_unit verification failed");
		$finish;
	end

endmodule
